// ===== sv/spline_point_evaluator_defines.svh =====
// Assertion macros used by the spline point evaluator queue.
`ifndef SPLINE_POINT_EVALUATOR_DEFINES_SVH
`define SPLINE_POINT_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spline point evaluator assertion failed");

// Next-cycle implication, checked outside reset.
`define SPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spline point evaluator assertion failed");

`endif

// ===== sv/spe_pkg.sv =====
// Shared types and constants of the spline point evaluator.
package spe_pkg;

    localparam int COORD_W     = 32;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int PARAM_W     = 17;
    localparam int INDEX_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int IN_DATA_W   = 120;
    localparam int COEF_W      = 36;
    localparam int QUEUE_DEPTH = 2;

    // x / 3 == (x * RECIP3) >> RECIP3_SHIFT for x below 2**17
    localparam int RECIP3       = 43691;
    localparam int RECIP3_SHIFT = 17;

    localparam logic [KIND_W-1:0] KIND_LINEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEZIER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CATMULL = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_KIND   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               closed;
        logic [COUNT_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              zero;
    } t_eval_ctl;

endpackage

// ===== sv/spe_front.sv =====
// Front end: accepts items, finds segment and point indices, writes and reads the point banks.
module spe_front #(
    parameter int MAX_POINTS = 64,
    parameter int F          = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spe_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [spe_pkg::INDEX_W-1:0]     i_index,
    input  logic [spe_pkg::POINT_W-1:0]     i_point,
    input  logic [spe_pkg::PARAM_W-1:0]     i_param,
    output logic                            o_push,
    input  logic                            i_full,
    output logic [4*spe_pkg::POINT_W+F+1+$bits(spe_pkg::t_eval_ctl)-1:0] o_entry
);

    localparam int NW   = $clog2(MAX_POINTS + 1);
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int TW   = F + 1;
    localparam int FW   = TW + NW;
    localparam int XW   = NW + 3;
    localparam int PRW  = NW + 17;
    localparam int CNTW = (NW > spe_pkg::COUNT_W) ? NW : spe_pkg::COUNT_W;
    localparam int CLW  = (spe_pkg::PARAM_W > TW) ? spe_pkg::PARAM_W : TW;
    localparam int ONE  = 1 << F;

    logic en;

    // stage 1
    logic [CNTW-1:0] cnt_ext;
    logic [NW-1:0]   n_c, nm1, sb, s_c;
    logic [PRW-1:0]  prod3;
    logic [CLW-1:0]  t_w;
    logic [TW-1:0]   t_c;
    logic [spe_pkg::KIND_W-1:0] kind_c;

    logic                        r1_v, r1_op, r1_closed, r1_zero, r1_single;
    logic [spe_pkg::INDEX_W-1:0] r1_idx;
    logic [spe_pkg::POINT_W-1:0] r1_pt;
    logic [FW-1:0]               r1_ft;
    logic [NW-1:0]               r1_s, r1_n;
    logic [spe_pkg::KIND_W-1:0]  r1_kind;

    // stage 2
    logic [NW-1:0]   ip, smax, seg;
    logic [TW-1:0]   u_c;
    logic [AW-1:0]   addr_c [4];
    logic            wok_c;

    logic                        r2_v, r2_op, r2_wok;
    logic [AW-1:0]               r2_wa;
    logic [spe_pkg::POINT_W-1:0] r2_pt;
    logic [AW-1:0]               r2_addr [4];
    logic [TW-1:0]               r2_u;
    spe_pkg::t_eval_ctl          r2_ctl;

    // stage 3: point banks, one per read port, all written alike
    logic [spe_pkg::POINT_W-1:0] r_mem [4][MAX_POINTS];
    logic [spe_pkg::POINT_W-1:0] r_rd  [4];
    logic                        r3_v;
    logic [TW-1:0]               r3_u;
    spe_pkg::t_eval_ctl          r3_ctl;

    assign en      = !r3_v || !i_full;
    assign o_ready = en;
    assign o_push  = r3_v && !i_full;
    assign o_entry = {r3_ctl, r3_u, r_rd[3], r_rd[2], r_rd[1], r_rd[0]};

    always_comb begin
        cnt_ext = CNTW'(i_cfg.count);
        n_c     = (cnt_ext > CNTW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(cnt_ext);
        nm1     = n_c - NW'(1);
        prod3   = PRW'(nm1) * PRW'(spe_pkg::RECIP3);
        sb      = NW'(prod3 >> spe_pkg::RECIP3_SHIFT);
        case (i_cfg.kind)
            spe_pkg::KIND_LINEAR: kind_c = spe_pkg::KIND_LINEAR;
            spe_pkg::KIND_BEZIER: kind_c = spe_pkg::KIND_BEZIER;
            default:              kind_c = spe_pkg::KIND_CATMULL;
        endcase
        if (n_c == NW'(1)) begin
            kind_c = spe_pkg::KIND_LINEAR;
        end
        if (n_c <= NW'(1)) begin
            s_c = NW'(1);
        end else if (kind_c == spe_pkg::KIND_BEZIER) begin
            s_c = (sb == '0) ? NW'(1) : sb;
        end else begin
            s_c = i_cfg.closed ? n_c : nm1;
        end
        t_w = CLW'(i_param);
        t_c = (t_w > CLW'(ONE)) ? TW'(ONE) : TW'(t_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
        if (en) begin
            r1_op     <= i_op;
            r1_idx    <= i_index;
            r1_pt     <= i_point;
            r1_ft     <= FW'(t_c) * FW'(s_c);
            r1_s      <= s_c;
            r1_n      <= n_c;
            r1_kind   <= kind_c;
            r1_closed <= i_cfg.closed;
            r1_zero   <= (n_c == '0);
            r1_single <= (n_c == NW'(1));
        end
    end

    always_comb begin
        logic signed [XW-1:0] ii, nn, cx;
        ii    = '0;
        nn    = '0;
        cx    = '0;
        ip    = NW'(r1_ft >> F);
        smax  = r1_s - NW'(1);
        seg   = (ip > smax) ? smax : ip;
        u_c   = TW'(r1_ft - (FW'(seg) << F));
        wok_c = int'(r1_idx) < MAX_POINTS;
        ii    = $signed(XW'(seg));
        nn    = $signed(XW'(r1_n));
        for (int k = 0; k < 4; k++) begin
            case (r1_kind)
                spe_pkg::KIND_LINEAR: begin
                    cx = ii + ((k == 0) ? XW'(0) : XW'(1));
                    if (cx >= nn) begin
                        cx = '0;
                    end
                end
                spe_pkg::KIND_BEZIER: begin
                    cx = ii + ii + ii + XW'(k);
                    if (cx > nn - XW'(1)) begin
                        cx = nn - XW'(1);
                    end
                end
                default: begin
                    cx = ii + XW'(k) - XW'(1);
                    if (r1_closed) begin
                        if (cx < 0) begin
                            cx = cx + nn;
                        end else if (cx >= nn) begin
                            cx = cx - nn;
                        end
                    end else if (cx < 0) begin
                        cx = '0;
                    end else if (cx > nn - XW'(1)) begin
                        cx = nn - XW'(1);
                    end
                end
            endcase
            if (r1_single || r1_zero) begin
                cx = '0;
            end
            addr_c[k] = AW'($unsigned(cx));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_op       <= r1_op;
            r2_wok      <= wok_c;
            r2_wa       <= AW'(r1_idx);
            r2_pt       <= r1_pt;
            r2_u        <= u_c;
            r2_ctl.kind <= r1_kind;
            r2_ctl.zero <= r1_zero;
            for (int k = 0; k < 4; k++) begin
                r2_addr[k] <= addr_c[k];
            end
        end
    end

    // writes land here, in item order with the reads
    always_ff @(posedge i_clk) begin
        if (en && r2_v && r2_op == spe_pkg::OP_WRITE && r2_wok) begin
            for (int b = 0; b < 4; b++) begin
                r_mem[b][r2_wa] <= r2_pt;
            end
        end
        if (en) begin
            for (int b = 0; b < 4; b++) begin
                r_rd[b] <= r_mem[b][r2_addr[b]];
            end
            r3_u   <= r2_u;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v && r2_op == spe_pkg::OP_EVAL;
        end
    end

endmodule

// ===== sv/spe_queue.sv =====
// Short queue of evaluate items between front and back end.
`include "spline_point_evaluator_defines.svh"

module spe_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = spe_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    `SPE_ASSERT_IMPL(a_push_room, i_push, !o_full)
    `SPE_ASSERT_IMPL(a_pop_data, i_pop, !o_empty)
    `SPE_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= CW'(DEPTH))
    `SPE_ASSERT_NEXT(a_cnt_up, i_push && !i_pop, r_cnt == $past(r_cnt) + CW'(1))

endmodule

// ===== sv/spe_back.sv =====
// Back end: weights, coefficient products and sums; one point per cycle unless the output stalls.
module spe_back #(
    parameter int F = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic [4*spe_pkg::POINT_W+F+1+$bits(spe_pkg::t_eval_ctl)-1:0] i_entry,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [spe_pkg::POINT_W-1:0] o_pos
);

    localparam int TW   = F + 1;
    localparam int WW   = F + 3;
    localparam int CTLW = $bits(spe_pkg::t_eval_ctl);
    localparam int QW   = 4 * spe_pkg::POINT_W + TW + CTLW;
    localparam int CF   = spe_pkg::COEF_W;
    localparam int PW0  = CF + WW + 1;
    localparam int SW   = PW0 + 2;
    localparam int CW   = spe_pkg::COORD_W;
    localparam logic [TW-1:0] ONE_T = TW'(1) << F;

    logic ben;

    spe_pkg::t_eval_ctl q_ctl;
    logic [TW-1:0]      q_u, q_v, q_u2, q_v2;
    logic [2*TW-1:0]    uu, vv;
    logic signed [CF-1:0] a_c [3][4];

    logic                 r1_v;
    spe_pkg::t_eval_ctl   r1_ctl;
    logic signed [CF-1:0] r1_a [3][4];
    logic [TW-1:0]        r1_u, r1_vp, r1_u2, r1_v2;

    logic [2*TW-1:0] uuu, vvv, v2u, vu2;
    logic [WW-1:0]   t1, t2;
    logic [WW-1:0]   w_c [4];

    logic                 r2_v;
    spe_pkg::t_eval_ctl   r2_ctl;
    logic signed [CF-1:0] r2_a [3][4];
    logic [WW-1:0]        r2_w [4];

    logic                  r3_v;
    spe_pkg::t_eval_ctl    r3_ctl;
    logic signed [PW0-1:0] r3_p [3][4];

    logic signed [SW-1:0]  sum_c [3];
    logic signed [SW-1:0]  sh_c  [3];

    logic                  r4_v;
    logic [spe_pkg::POINT_W-1:0] r4_pos;

    assign ben     = !r4_v || i_ready;
    assign o_pop   = ben && !i_empty;
    assign o_valid = r4_v;
    assign o_pos   = r4_pos;

    always_comb begin
        logic signed [CF-1:0] e0, e1, e2, e3;
        e0 = '0;
        e1 = '0;
        e2 = '0;
        e3 = '0;
        q_ctl = spe_pkg::t_eval_ctl'(i_entry[QW-1 -: CTLW]);
        q_u   = i_entry[4*spe_pkg::POINT_W +: TW];
        q_v   = ONE_T - q_u;
        uu    = (2*TW)'(q_u) * (2*TW)'(q_u);
        vv    = (2*TW)'(q_v) * (2*TW)'(q_v);
        q_u2  = TW'(uu >> F);
        q_v2  = TW'(vv >> F);
        for (int c = 0; c < 3; c++) begin
            e0 = CF'($signed(i_entry[0*spe_pkg::POINT_W + c*CW +: CW]));
            e1 = CF'($signed(i_entry[1*spe_pkg::POINT_W + c*CW +: CW]));
            e2 = CF'($signed(i_entry[2*spe_pkg::POINT_W + c*CW +: CW]));
            e3 = CF'($signed(i_entry[3*spe_pkg::POINT_W + c*CW +: CW]));
            case (q_ctl.kind)
                spe_pkg::KIND_LINEAR: begin
                    a_c[c][0] = e0;
                    a_c[c][1] = e1 - e0;
                    a_c[c][2] = '0;
                    a_c[c][3] = '0;
                end
                spe_pkg::KIND_BEZIER: begin
                    a_c[c][0] = e0;
                    a_c[c][1] = e1;
                    a_c[c][2] = e2;
                    a_c[c][3] = e3;
                end
                default: begin
                    a_c[c][0] = e1 + e1;
                    a_c[c][1] = e2 - e0;
                    a_c[c][2] = e0 + e0 - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
                    a_c[c][3] = (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
                end
            endcase
            if (q_ctl.zero) begin
                for (int k = 0; k < 4; k++) begin
                    a_c[c][k] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (ben) begin
            r1_v <= !i_empty;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r1_ctl <= q_ctl;
            r1_a   <= a_c;
            r1_u   <= q_u;
            r1_vp  <= q_v;
            r1_u2  <= q_u2;
            r1_v2  <= q_v2;
        end
    end

    always_comb begin
        uuu = (2*TW)'(r1_u2) * (2*TW)'(r1_u);
        vvv = (2*TW)'(r1_v2) * (2*TW)'(r1_vp);
        v2u = (2*TW)'(r1_v2) * (2*TW)'(r1_u);
        vu2 = (2*TW)'(r1_vp) * (2*TW)'(r1_u2);
        t1  = WW'(v2u >> F);
        t2  = WW'(vu2 >> F);
        case (r1_ctl.kind)
            spe_pkg::KIND_LINEAR: begin
                w_c[0] = WW'(ONE_T);
                w_c[1] = WW'(r1_u);
                w_c[2] = '0;
                w_c[3] = '0;
            end
            spe_pkg::KIND_BEZIER: begin
                w_c[0] = WW'(vvv >> F);
                w_c[1] = t1 + (t1 << 1);
                w_c[2] = t2 + (t2 << 1);
                w_c[3] = WW'(uuu >> F);
            end
            default: begin
                w_c[0] = WW'(ONE_T);
                w_c[1] = WW'(r1_u);
                w_c[2] = WW'(r1_u2);
                w_c[3] = WW'(uuu >> F);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r2_ctl <= r1_ctl;
            r2_a   <= r1_a;
            r2_w   <= w_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r3_ctl <= r2_ctl;
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r3_p[c][k] <= PW0'(r2_a[c][k]) * PW0'($signed({1'b0, r2_w[k]}));
                end
            end
        end
    end

    // catmull-rom carries an extra factor of two
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum_c[c] = SW'(r3_p[c][0]) + SW'(r3_p[c][1]) + SW'(r3_p[c][2])
                     + SW'(r3_p[c][3]);
            if (r3_ctl.kind == spe_pkg::KIND_CATMULL) begin
                sh_c[c] = sum_c[c] >>> (F + 1);
            end else begin
                sh_c[c] = sum_c[c] >>> F;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r4_pos <= {sh_c[2][CW-1:0], sh_c[1][CW-1:0], sh_c[0][CW-1:0]};
        end
    end

endmodule

// ===== sv/spline_point_evaluator.sv =====
// Spline point evaluator top level: configuration registers, front, queue, back.
//
//  channel | direction | handshake                    | payload
//  s       | in        | i_s_tvalid / o_s_tready      | i_s_tdata, i_s_tuser
//  m       | out       | o_m_tvalid / i_m_tready      | o_m_tdata
//  cfg     | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output accepts; o_m_tvalid rises once the evaluate
// item has passed 3 front stages ending in the point bank read, the queue and 4 back stages.
// Point writes take effect at the bank stage, in item order with evaluates.
// Reset clears control state only; the point store holds garbage until written.
// Output stalls freeze the back end, fill the 2-item queue, then drop o_s_tready.
module spline_point_evaluator #(
    parameter int MAX_POINTS      = 64,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // point_index, coord_x, coord_y, coord_z, curve_param, zero pad
    input  logic [spe_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // operation
    input  logic [0:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pos_x, pos_y, pos_z
    output logic [spe_pkg::POINT_W-1:0]     o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spe_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [spe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int QW = 4 * spe_pkg::POINT_W + PARAM_FRAC_BITS + 1
                      + $bits(spe_pkg::t_eval_ctl);
    localparam int PT_LO = spe_pkg::INDEX_W;
    localparam int PM_LO = PT_LO + spe_pkg::POINT_W;

    spe_pkg::t_cfg   r_cfg;
    logic            push, full, pop, empty;
    logic [QW-1:0]   push_data, pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind   <= spe_pkg::KIND_CATMULL;
            r_cfg.closed <= 1'b0;
            r_cfg.count  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spe_pkg::REG_KIND:   r_cfg.kind   <= i_cfg_data[spe_pkg::KIND_W-1:0];
                spe_pkg::REG_CLOSED: r_cfg.closed <= i_cfg_data[0];
                spe_pkg::REG_COUNT:  r_cfg.count  <= i_cfg_data[spe_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    spe_front #(
        .MAX_POINTS (MAX_POINTS),
        .F          (PARAM_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser[0]),
        .i_index (i_s_tdata[spe_pkg::INDEX_W-1:0]),
        .i_point (i_s_tdata[PT_LO +: spe_pkg::POINT_W]),
        .i_param (i_s_tdata[PM_LO +: spe_pkg::PARAM_W]),
        .o_push  (push),
        .i_full  (full),
        .o_entry (push_data)
    );

    spe_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (empty)
    );

    spe_back #(
        .F (PARAM_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .o_pop   (pop),
        .i_entry (pop_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pos   (o_m_tdata)
    );

endmodule

// ===== tb/tb_spline_point_evaluator.sv =====
// Self-checking testbench for the spline point evaluator.
`timescale 1ns / 1ps

module tb_spline_point_evaluator;

    localparam logic [spe_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [spe_pkg::IN_DATA_W-1:0]   i_s_tdata;
    logic [0:0]                      i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [spe_pkg::POINT_W-1:0]     o_m_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [spe_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [spe_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    spline_point_evaluator dut (.*);

    // local copy of the block's state
    logic [spe_pkg::COORD_W-1:0] pt_x [64];
    logic [spe_pkg::COORD_W-1:0] pt_y [64];
    logic [spe_pkg::COORD_W-1:0] pt_z [64];
    logic [spe_pkg::KIND_W-1:0]  cur_kind;
    logic                        cur_closed;
    logic [spe_pkg::COUNT_W-1:0] cur_count;

    logic [spe_pkg::POINT_W-1:0] pending_pos [$];
    int err_cnt;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_req;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint coord(int k, int c);
        logic [spe_pkg::COORD_W-1:0] w;
        w = (c == 0) ? pt_x[k] : (c == 1) ? pt_y[k] : pt_z[k];
        return longint'(signed'(w));
    endfunction

    function automatic logic [spe_pkg::POINT_W-1:0] curve_pos(
        logic [spe_pkg::PARAM_W-1:0] t_in);
        longint one, t, ft, u, u2, u3, v, v2, acc, a0, a1, a2, a3;
        longint w [4];
        int n, s, i, k, c;
        int idx [4];
        logic [spe_pkg::POINT_W-1:0] r;
        one = 64'sd65536;
        n = (cur_count > 64) ? 64 : int'(cur_count);
        t = longint'(t_in);
        if (t > one) t = one;
        if (n == 0) return '0;
        if (n == 1) return {pt_z[0], pt_y[0], pt_x[0]};
        if (cur_kind == spe_pkg::KIND_BEZIER) begin
            s = (n - 1) / 3;
            if (s < 1) s = 1;
        end else begin
            s = cur_closed ? n : n - 1;
        end
        ft = t * s;
        i = int'(ft >>> 16);
        if (i > s - 1) i = s - 1;
        u = ft - (longint'(i) <<< 16);
        u2 = (u * u) >>> 16;
        u3 = (u2 * u) >>> 16;
        for (c = 0; c < 3; c++) begin
            if (cur_kind == spe_pkg::KIND_LINEAR) begin
                a0 = coord(i % n, c);
                a1 = coord((i + 1) % n, c);
                acc = a0 + (((a1 - a0) * u) >>> 16);
            end else if (cur_kind == spe_pkg::KIND_BEZIER) begin
                v = one - u;
                v2 = (v * v) >>> 16;
                w[0] = (v2 * v) >>> 16;
                w[1] = 3 * ((v2 * u) >>> 16);
                w[2] = 3 * ((v * u2) >>> 16);
                w[3] = u3;
                acc = 0;
                for (k = 0; k < 4; k++)
                    acc += coord((3 * i + k < n) ? 3 * i + k : n - 1, c) * w[k];
                acc = acc >>> 16;
            end else begin
                // the reserved kind falls through to catmull-rom
                for (k = 0; k < 4; k++) begin
                    idx[k] = i - 1 + k;
                    if (cur_closed) idx[k] = ((idx[k] % n) + n) % n;
                    else if (idx[k] < 0) idx[k] = 0;
                    else if (idx[k] > n - 1) idx[k] = n - 1;
                end
                a0 = coord(idx[0], c);
                a1 = coord(idx[1], c);
                a2 = coord(idx[2], c);
                a3 = coord(idx[3], c);
                acc = 2 * a1 * one + (a2 - a0) * u + (2 * a0 - 5 * a1 + 4 * a2 - a3) * u2
                    + (3 * a1 - a0 - 3 * a2 + a3) * u3;
                acc = acc >>> 17;
            end
            r[c*spe_pkg::COORD_W +: spe_pkg::COORD_W] = acc[spe_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    // one item on the input stream; called right after a rising edge
    task automatic send_item(logic op, logic [spe_pkg::INDEX_W-1:0] idx,
                             logic [spe_pkg::COORD_W-1:0] x,
                             logic [spe_pkg::COORD_W-1:0] y,
                             logic [spe_pkg::COORD_W-1:0] z,
                             logic [spe_pkg::PARAM_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {1'b0, t, z, y, x, idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (op == spe_pkg::OP_WRITE) begin
            pt_x[idx] = x;
            pt_y[idx] = y;
            pt_z[idx] = z;
        end else begin
            pending_pos = {pending_pos, curve_pos(t)};
        end
    endtask

    task automatic write_point(int idx);
        logic [spe_pkg::COORD_W-1:0] c [3];
        for (int k = 0; k < 3; k++)
            case ($urandom_range(5))
                0: c[k] = 32'h8000_0000;
                1: c[k] = 32'h7fff_ffff;
                2: c[k] = $urandom_range(65535) << 16;
                default: c[k] = $urandom;
            endcase
        send_item(spe_pkg::OP_WRITE, idx[spe_pkg::INDEX_W-1:0], c[0], c[1], c[2], '0);
    endtask

    task automatic eval_at(logic [spe_pkg::PARAM_W-1:0] t);
        send_item(spe_pkg::OP_EVAL, spe_pkg::INDEX_W'($urandom), spe_pkg::COORD_W'($urandom),
                  spe_pkg::COORD_W'($urandom), spe_pkg::COORD_W'($urandom), t);
    endtask

    function automatic logic [spe_pkg::PARAM_W-1:0] rand_param();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return spe_pkg::PARAM_W'($urandom_range(131071, 65537));
            default: return spe_pkg::PARAM_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic drain();
        int waited;
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (pending_pos.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_pos.size() != 0) begin
            $error("%0d results never arrived", pending_pos.size());
            err_cnt++;
            pending_pos.delete();
        end
        // writes may still be in flight
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [spe_pkg::CFG_INDEX_W-1:0] idx,
                             logic [spe_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            spe_pkg::REG_KIND:   cur_kind   = val[spe_pkg::KIND_W-1:0];
            spe_pkg::REG_CLOSED: cur_closed = val[0];
            default:             cur_count  = val;
        endcase
    endtask

    task automatic set_curve(int kind, int closed, int count);
        write_reg(spe_pkg::REG_KIND, spe_pkg::CFG_DATA_W'(kind));
        write_reg(spe_pkg::REG_CLOSED, spe_pkg::CFG_DATA_W'(closed));
        write_reg(spe_pkg::REG_COUNT, spe_pkg::CFG_DATA_W'(count));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_empty();
        eval_at(17'd32768);
        drain();
    endtask

    task automatic test_fill_store();
        for (int k = 0; k < 64; k++) write_point(k);
        drain();
    endtask

    task automatic test_directed();
        // reset settings with no points, then one point, then the corner settings
        eval_at(17'd32768);
        drain();
        set_curve(spe_pkg::KIND_LINEAR, 0, 1);
        eval_at(17'd40000);
        drain();
        set_curve(spe_pkg::KIND_LINEAR, 1, 2);
        eval_at(17'd0);
        eval_at(17'd65536);
        eval_at(17'd131071);
        drain();
        set_curve(spe_pkg::KIND_BEZIER, 0, 4);
        eval_at(17'd0);
        eval_at(17'd21845);
        eval_at(17'd65536);
        drain();
        set_curve(spe_pkg::KIND_BEZIER, 1, 3);
        eval_at(17'd32768);
        drain();
        set_curve(spe_pkg::KIND_CATMULL, 1, 64);
        eval_at(17'd65535);
        eval_at(17'd1);
        drain();
        // unknown kind and oversized count
        set_curve(KIND_RESERVED, 0, 127);
        eval_at(17'd50000);
        eval_at(17'd65536);
        write_point(63);
        eval_at(17'd65536);
        drain();
    endtask

    task automatic test_random(int items, int idle, int stall);
        int ks [4];
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        ks = '{spe_pkg::KIND_LINEAR, spe_pkg::KIND_BEZIER, spe_pkg::KIND_CATMULL,
               KIND_RESERVED};
        for (int k = 0; k < items; k++) begin
            if (k % 25 == 0) begin
                drain();
                set_curve(ks[$urandom_range(3)], $urandom_range(1),
                          ($urandom_range(3) == 0) ? $urandom_range(127) :
                          ($urandom_range(1) ? 64 : $urandom_range(8)));
            end
            if ($urandom_range(4) == 0) write_point($urandom_range(63));
            else eval_at(rand_param());
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_curve(spe_pkg::KIND_CATMULL, 0, 64);
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++) eval_at(rand_param());
        drain();
    endtask

    // output side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= 300;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [spe_pkg::POINT_W-1:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pos.size() == 0) begin
                $error("unexpected result %h", o_m_tdata);
                err_cnt++;
            end else begin
                want = pending_pos.pop_front();
                for (int c = 0; c < 3; c++)
                    if (want[c*spe_pkg::COORD_W +: spe_pkg::COORD_W]
                        !== o_m_tdata[c*spe_pkg::COORD_W +: spe_pkg::COORD_W]) begin
                        $error("pos_%s expected %h actual %h",
                               (c == 0) ? "x" : (c == 1) ? "y" : "z",
                               want[c*spe_pkg::COORD_W +: spe_pkg::COORD_W],
                               o_m_tdata[c*spe_pkg::COORD_W +: spe_pkg::COORD_W]);
                        err_cnt++;
                    end
            end
        end
    end

    initial begin
        #(12ns * 2000000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        err_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        hold_req = 1'b0;
        cur_kind = spe_pkg::KIND_CATMULL;
        cur_closed = 1'b0;
        cur_count = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty();
        test_fill_store();
        test_directed();
        test_random(75, 0, 0);
        test_random(75, 68, 0);
        test_random(75, 0, 68);
        test_random(75, 37, 37);
        test_backpressure();
        if (err_cnt == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
